FILE: hdl/axv_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the ACL extended attribute validator.
// Used by every module under hdl; no dependencies.
package axv_pkg;

  localparam int unsigned WordWidth = 32;
  localparam int unsigned TagWidth  = 16;
  localparam int unsigned PermWidth = 16;
  localparam int unsigned CfgIndexWidth = 2;

  localparam logic [TagWidth-1:0] TAG_USER_OBJ  = 16'd1;
  localparam logic [TagWidth-1:0] TAG_USER      = 16'd2;
  localparam logic [TagWidth-1:0] TAG_GROUP_OBJ = 16'd4;
  localparam logic [TagWidth-1:0] TAG_GROUP     = 16'd8;
  localparam logic [TagWidth-1:0] TAG_MASK      = 16'd16;
  localparam logic [TagWidth-1:0] TAG_OTHER     = 16'd32;

  localparam logic [PermWidth-1:0] PERM_ALLOWED = 16'd7;

  localparam logic [WordWidth-1:0] ExpectedVersionReset = 32'd2;
  localparam logic [WordWidth-1:0] InvalidUserIdReset   = 32'hFFFF_FFFF;
  localparam logic [WordWidth-1:0] InvalidGroupIdReset  = 32'hFFFF_FFFF;

  typedef enum logic [CfgIndexWidth-1:0] {
    CFG_EXPECTED_VERSION = 2'd0,
    CFG_INVALID_USER_ID  = 2'd1,
    CFG_INVALID_GROUP_ID = 2'd2
  } cfg_index_t;

  typedef enum logic {
    ACT_HEADER = 1'b0,
    ACT_ENTRY  = 1'b1
  } action_t;

  typedef enum logic [1:0] {
    STATUS_OK     = 2'd0,
    STATUS_HEADER = 2'd1,
    STATUS_FIELD  = 2'd2,
    STATUS_ORDER  = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    PH_START  = 3'd0,
    PH_USERS  = 3'd1,
    PH_GROUPS = 3'd2,
    PH_MASKED = 3'd3,
    PH_DONE   = 3'd4
  } phase_t;

  typedef struct packed {
    logic                 action;
    logic [WordWidth-1:0] version;
    logic [TagWidth-1:0]  entry_tag;
    logic [PermWidth-1:0] permission;
    logic [WordWidth-1:0] qualifier;
    logic                 last;
  } item_t;

  typedef struct packed {
    logic [1:0] status;
    logic       has_named_entries;
  } result_t;

  typedef struct packed {
    logic [WordWidth-1:0] expected_version;
    logic [WordWidth-1:0] invalid_user_id;
    logic [WordWidth-1:0] invalid_group_id;
  } cfg_t;

endpackage

FILE: hdl/axv_cfg.sv
`timescale 1ns / 1ps
// Configuration register file of the ACL validator.
// Depends on axv_pkg.
module axv_cfg
  import axv_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_write,
  input  logic [CfgIndexWidth-1:0] cfg_index,
  input  logic [WordWidth-1:0]     cfg_data,
  output cfg_t                     cfg
);

  cfg_t regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.expected_version <= ExpectedVersionReset;
      regs.invalid_user_id  <= InvalidUserIdReset;
      regs.invalid_group_id <= InvalidGroupIdReset;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_EXPECTED_VERSION: regs.expected_version <= cfg_data;
        CFG_INVALID_USER_ID:  regs.invalid_user_id  <= cfg_data;
        CFG_INVALID_GROUP_ID: regs.invalid_group_id <= cfg_data;
        default: ;
      endcase
    end
  end

  assign cfg = regs;

endmodule

FILE: hdl/axv_engine.sv
`timescale 1ns / 1ps
// Per-attribute checking state: field checks, order tracking and status.
// Depends on axv_pkg.
module axv_engine
  import axv_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    step,
  input  item_t   item,
  input  cfg_t    cfg,
  output result_t result
);

  phase_t phase, phase_next;
  logic   named_seen, named_seen_next;
  logic   field_err, field_err_next;
  logic   header_err, header_err_next;
  logic   order_err, order_err_next;

  logic   field_bad;
  logic   order_ok;
  phase_t ph_upd;
  logic   need_upd;

  always_comb begin
    field_bad = 1'b0;
    case (item.entry_tag)
      TAG_USER:  field_bad = (item.qualifier == cfg.invalid_user_id);
      TAG_GROUP: field_bad = (item.qualifier == cfg.invalid_group_id);
      TAG_USER_OBJ, TAG_GROUP_OBJ, TAG_MASK, TAG_OTHER: field_bad = 1'b0;
      default:   field_bad = 1'b1;
    endcase
    if ((item.permission & ~PERM_ALLOWED) != '0) field_bad = 1'b1;
  end

  always_comb begin
    order_ok = 1'b1;
    ph_upd   = phase;
    need_upd = named_seen;
    unique case (phase)
      PH_START: begin
        if (item.entry_tag == TAG_USER_OBJ) ph_upd = PH_USERS;
        else order_ok = 1'b0;
      end
      PH_USERS: begin
        if (item.entry_tag == TAG_USER) need_upd = 1'b1;
        else if (item.entry_tag == TAG_GROUP_OBJ) ph_upd = PH_GROUPS;
        else order_ok = 1'b0;
      end
      PH_GROUPS: begin
        if (item.entry_tag == TAG_GROUP) need_upd = 1'b1;
        else if (item.entry_tag == TAG_MASK) ph_upd = PH_MASKED;
        else if (item.entry_tag == TAG_OTHER && !named_seen) ph_upd = PH_DONE;
        else order_ok = 1'b0;
      end
      PH_MASKED: begin
        if (item.entry_tag == TAG_OTHER) ph_upd = PH_DONE;
        else order_ok = 1'b0;
      end
      default: ;
    endcase
  end

  // state after this item, before closing on last
  phase_t ph_a;
  logic   need_a, ferr_a, herr_a, oerr_a;

  always_comb begin
    if (item.action == ACT_HEADER) begin
      ph_a   = PH_START;
      need_a = 1'b0;
      ferr_a = 1'b0;
      oerr_a = 1'b0;
      herr_a = (item.version != cfg.expected_version);
    end else begin
      ferr_a = field_err | field_bad;
      herr_a = header_err;
      if (order_err) begin
        ph_a   = phase;
        need_a = named_seen;
        oerr_a = 1'b1;
      end else begin
        ph_a   = ph_upd;
        need_a = need_upd;
        oerr_a = !order_ok;
      end
    end
  end

  always_comb begin
    if (herr_a) result.status = STATUS_HEADER;
    else if (ferr_a) result.status = STATUS_FIELD;
    else if (oerr_a || ph_a != PH_DONE) result.status = STATUS_ORDER;
    else result.status = STATUS_OK;
    result.has_named_entries = herr_a ? 1'b0 : need_a;
  end

  always_comb begin
    if (item.last) begin
      phase_next      = PH_START;
      named_seen_next = 1'b0;
      field_err_next  = 1'b0;
      header_err_next = 1'b1;
      order_err_next  = 1'b0;
    end else begin
      phase_next      = ph_a;
      named_seen_next = need_a;
      field_err_next  = ferr_a;
      header_err_next = herr_a;
      order_err_next  = oerr_a;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_START;
      named_seen <= 1'b0;
      field_err  <= 1'b0;
      header_err <= 1'b1;
      order_err  <= 1'b0;
    end else if (step) begin
      phase      <= phase_next;
      named_seen <= named_seen_next;
      field_err  <= field_err_next;
      header_err <= header_err_next;
      order_err  <= order_err_next;
    end
  end

endmodule

FILE: hdl/acl_xattr_validator.sv
`timescale 1ns / 1ps
// Top level of the ACL extended attribute validator.
// Depends on axv_pkg, axv_cfg and axv_engine.
//
// Validates a POSIX ACL attribute sent as one header item followed by entry
// items; one result comes out for each item marked last. The block takes one
// item per clock while no stalled result is waiting: an input register feeds
// the checking logic, whose per attribute state updates once per item, and a
// result register drives the output. A result is valid from the clock edge
// after the one that accepts its item, unless an earlier result is still
// waiting. Stall on the result side, only while a result is waiting, holds
// the result register and the input register; otherwise items keep flowing.
// Configuration must be written only while no item is in flight.
module acl_xattr_validator
  import axv_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     item_valid,
  output logic                     item_stall,
  input  item_t                    item,
  output logic                     result_valid,
  input  logic                     result_stall,
  output result_t                  result,
  input  logic                     cfg_write,
  input  logic [CfgIndexWidth-1:0] cfg_index,
  input  logic [WordWidth-1:0]     cfg_data
);

  cfg_t    cfg;
  logic    s1_valid;
  item_t   s1_item;
  logic    s1_adv;
  logic    accept;
  logic    fire;
  result_t eng_result;
  result_t res_reg;
  logic    res_valid;

  axv_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  axv_engine u_engine (
    .clk    (clk),
    .rst    (rst),
    .step   (fire),
    .item   (s1_item),
    .cfg    (cfg),
    .result (eng_result)
  );

  assign s1_adv     = !res_valid || !result_stall;
  assign item_stall = s1_valid && !s1_adv;
  assign accept     = item_valid && !item_stall;
  assign fire       = s1_valid && s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_item <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (s1_adv) begin
      res_valid <= fire && s1_item.last;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && s1_item.last) begin
      res_reg <= eng_result;
    end
  end

  assign result_valid = res_valid;
  assign result       = res_reg;

endmodule

FILE: hdl/axv_checker.sv
`timescale 1ns / 1ps
// Port-level checks for acl_xattr_validator, bound to the top level.
// Depends on axv_pkg.
module axv_checker
  import axv_pkg::*;
(
  input logic    clk,
  input logic    rst,
  input logic    item_stall,
  input logic    result_valid,
  input logic    result_stall,
  input result_t result
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("result changed while stalled");

  a_hdr_named: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.status == STATUS_HEADER |-> !result.has_named_entries)
    else $error("named flag set on header failure");

  a_reset: assert property (@(posedge clk)
    rst |=> !result_valid && !item_stall)
    else $error("pipeline not empty after reset");

  a_no_input_stall: assert property (@(posedge clk) disable iff (rst)
    !result_valid |-> !item_stall)
    else $error("input stalled with empty result register");

endmodule

bind acl_xattr_validator axv_checker u_axv_checker (
  .clk          (clk),
  .rst          (rst),
  .item_stall   (item_stall),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result       (result)
);
